/* src/tqla_pkg.sv */
// tqla_pkg: shared types and constants for the tabular q-learning agent
// no dependencies
package tqla_pkg;

  localparam int STATES   = 1024;
  localparam int ACTIONS  = 16;
  localparam int STATE_W  = $clog2(STATES);
  localparam int ACT_W    = $clog2(ACTIONS);
  localparam int ADDR_W   = STATE_W + ACT_W;
  localparam int DEPTH    = STATES * ACTIONS;
  localparam int Q_W      = 32;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DAT_W = 16;
  localparam int NACT_W   = 5;

  typedef enum logic [1:0] {
    OP_CHOOSE  = 2'd0,
    OP_UPDATE  = 2'd1,
    OP_END_EP  = 2'd2,
    OP_RESTART = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    REG_LR       = 3'd0,
    REG_GAMMA    = 3'd1,
    REG_EXP_INIT = 3'd2,
    REG_EXP_MIN  = 3'd3,
    REG_EXP_STEP = 3'd4,
    REG_NACT     = 3'd5
  } cfg_reg_t;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SCAN,
    ST_SCAN_LAST,
    ST_RD_Q,
    ST_MUL_G,
    ST_SUM_T,
    ST_MUL_D,
    ST_WRITE,
    ST_OUT
  } state_t;

  // table port control from the sequencer
  typedef struct packed {
    logic              rd_en;
    logic [ADDR_W-1:0] rd_addr;
    logic              wr_en;
    logic [ADDR_W-1:0] wr_addr;
    logic [Q_W-1:0]    wr_data;
  } qmem_req_t;

endpackage

/* src/tqla_qmem.sv */
// tqla_qmem: single-port-write, single-port-read q table memory, read data registered
// depends on tqla_pkg
module tqla_qmem
  import tqla_pkg::*;
(
  input  logic           clk,
  input  qmem_req_t      req,
  output logic [Q_W-1:0] rd_data
);

  logic [Q_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem[req.wr_addr] <= req.wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (req.rd_en) begin
      rd_data <= mem[req.rd_addr];
    end
  end

endmodule

/* src/tqla_ctrl.sv */
// tqla_ctrl: sequencer that clears the table after reset, scans rows, runs the q update and manages exploration
// depends on tqla_pkg
module tqla_ctrl
  import tqla_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic [15:0]          lr,
  input  logic [15:0]          gamma,
  input  logic [15:0]          exp_init,
  input  logic [15:0]          exp_min,
  input  logic [15:0]          exp_step,
  input  logic [NACT_W-1:0]    nact_cfg,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [1:0]           in_action,
  input  logic [STATE_W-1:0]   in_state_index,
  input  logic [STATE_W-1:0]   in_from_state,
  input  logic [STATE_W-1:0]   in_next_state,
  input  logic [ACT_W-1:0]     in_taken_move,
  input  logic signed [15:0]   in_reward,
  input  logic                 in_episode_done,
  input  logic [15:0]          in_rand_value,
  input  logic [15:0]          in_rand_pick,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [ACT_W-1:0]     out_chosen_move,
  output logic                 out_random_used,
  output logic signed [Q_W-1:0] out_q_written,
  output logic [15:0]          out_explore_now,
  output qmem_req_t            mreq,
  input  logic [Q_W-1:0]       mdata
);

  state_t state_r, state_nxt;

  logic                 is_upd_r;
  logic                 done_r;
  logic [STATE_W-1:0]   scan_row_r;
  logic [STATE_W-1:0]   upd_row_r;
  logic [ACT_W-1:0]     move_r;
  logic signed [15:0]   reward_r;
  logic [15:0]          rval_r, rpick_r;
  logic [ACT_W:0]       n_r;          // effective action count
  logic [ACT_W:0]       idx_r;        // next index to issue
  logic [ACT_W:0]       cmp_r;        // index of data arriving
  logic signed [Q_W-1:0] best_r;
  logic [ACT_W-1:0]     arg_r;
  logic signed [Q_W-1:0] q_old_r;
  logic signed [Q_W+16:0] g_r;        // gamma * m, wide
  logic signed [Q_W+17:0] t_r;
  logic signed [Q_W+34:0] d_r;
  logic [15:0]          explore_r;
  logic [ADDR_W-1:0]    clr_r;
  logic [4:0]           rem_r;        // rand_pick mod n, bit-serial remainder
  logic [4:0]           rbit_r;
  logic                 out_valid_r;
  logic [ACT_W-1:0]     o_move_r;
  logic                 o_rand_r;
  logic signed [Q_W-1:0] o_q_r;

  logic [ACT_W:0] n_eff;
  always_comb begin
    if (nact_cfg == '0) n_eff = (ACT_W+1)'(1);
    else if (nact_cfg > NACT_W'(ACTIONS)) n_eff = (ACT_W+1)'(ACTIONS);
    else n_eff = nact_cfg[ACT_W:0];
  end

  logic accept;
  assign accept   = in_valid && !in_stall;
  assign in_stall = (state_r != ST_IDLE) || out_valid_r;

  logic scan_last_issue;
  assign scan_last_issue = (idx_r + 1'b1 == n_r);

  logic signed [Q_W-1:0] mdata_s;
  assign mdata_s = mdata;

  // next bit of rand_pick shifted into the partial remainder
  logic       rp_bit;
  logic [5:0] rem_sh;
  assign rp_bit = rpick_r[rbit_r[3:0] - 4'd1];
  assign rem_sh = {1'b0, rem_r[3:0], rp_bit};

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_CLEAR:     if (clr_r == ADDR_W'(DEPTH - 1)) state_nxt = ST_IDLE;
      ST_IDLE: begin
        if (accept) begin
          case (op_t'(in_action))
            OP_CHOOSE: state_nxt = ST_SCAN;
            OP_UPDATE: state_nxt = in_episode_done ? ST_WRITE : ST_SCAN;
            default:   state_nxt = ST_OUT;
          endcase
        end
      end
      ST_SCAN:      if (scan_last_issue) state_nxt = ST_SCAN_LAST;
      ST_SCAN_LAST: begin
        if (!is_upd_r) state_nxt = (rbit_r == 5'd0) ? ST_OUT : ST_SCAN_LAST;
        else state_nxt = ST_RD_Q;
      end
      ST_RD_Q:      state_nxt = ST_MUL_G;
      ST_MUL_G:     state_nxt = ST_SUM_T;
      ST_SUM_T:     state_nxt = ST_MUL_D;
      ST_MUL_D:     state_nxt = ST_WRITE;
      ST_WRITE:     state_nxt = ST_OUT;
      ST_OUT:       state_nxt = ST_IDLE;
      default:      state_nxt = ST_IDLE;
    endcase
  end

  // saturated new value
  logic signed [Q_W+35:0] nv_w;
  logic signed [Q_W-1:0]  nv_sat;
  always_comb begin
    nv_w = (Q_W+36)'(q_old_r) + (Q_W+36)'(d_r >>> 16);
    if (nv_w > (Q_W+36)'(32'sh7FFFFFFF)) nv_sat = 32'sh7FFFFFFF;
    else if (nv_w < -(Q_W+36)'(64'sh80000000)) nv_sat = 32'sh80000000;
    else nv_sat = nv_w[Q_W-1:0];
  end

  logic signed [Q_W-1:0] wval;
  assign wval = done_r ? {reward_r, 16'h0000} : nv_sat;

  // memory port outputs
  always_comb begin
    mreq = '0;
    case (state_r)
      ST_CLEAR: begin
        mreq.wr_en   = 1'b1;
        mreq.wr_addr = clr_r;
      end
      ST_SCAN: begin
        mreq.rd_en   = 1'b1;
        mreq.rd_addr = {scan_row_r, idx_r[ACT_W-1:0]};
      end
      ST_SCAN_LAST: begin
        mreq.rd_en   = is_upd_r;
        mreq.rd_addr = {upd_row_r, move_r};
      end
      ST_WRITE: begin
        mreq.wr_en   = 1'b1;
        mreq.wr_addr = {upd_row_r, move_r};
        mreq.wr_data = wval;
      end
      default: ;
    endcase
  end

  // best-so-far update from arriving data
  logic scan_data;
  assign scan_data = (state_r == ST_SCAN && idx_r != '0) || (state_r == ST_SCAN_LAST &&
                     cmp_r < n_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      clr_r       <= '0;
      explore_r   <= 16'hFFFF;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (state_r == ST_CLEAR) clr_r <= clr_r + 1'b1;
      if (out_valid_r && !out_stall) out_valid_r <= 1'b0;
      if (state_r == ST_OUT) out_valid_r <= 1'b1;
      if (accept && op_t'(in_action) == OP_END_EP) begin
        if (explore_r > exp_min)
          explore_r <= (explore_r > exp_step) ? explore_r - exp_step : 16'd0;
      end
      if (accept && op_t'(in_action) == OP_RESTART) explore_r <= exp_init;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == ST_IDLE && accept) begin
      is_upd_r   <= op_t'(in_action) == OP_UPDATE;
      done_r     <= in_episode_done;
      scan_row_r <= (op_t'(in_action) == OP_CHOOSE) ? in_state_index : in_next_state;
      upd_row_r  <= in_from_state;
      move_r     <= in_taken_move;
      reward_r   <= in_reward;
      rval_r     <= in_rand_value;
      rpick_r    <= in_rand_pick;
      n_r        <= n_eff;
      idx_r      <= '0;
      cmp_r      <= '0;
      rem_r      <= '0;
      rbit_r     <= 5'd16;
      o_move_r   <= '0;
      o_rand_r   <= 1'b0;
      o_q_r      <= '0;
    end
    if (state_r == ST_SCAN) idx_r <= idx_r + 1'b1;
    if (state_r == ST_SCAN && idx_r != '0) cmp_r <= cmp_r + 1'b1;
    if (state_r == ST_SCAN_LAST && cmp_r < n_r) cmp_r <= cmp_r + 1'b1;
    if (scan_data) begin
      if (cmp_r == '0 || mdata_s > best_r) begin
        best_r <= mdata_s;
        arg_r  <= cmp_r[ACT_W-1:0];
      end
    end
    // rand_pick mod n, one bit per cycle during the scan tail
    if ((state_r == ST_SCAN_LAST) && !is_upd_r && rbit_r != 5'd0) begin
      if (rem_sh >= {1'b0, n_r})
        rem_r <= 5'(rem_sh - {1'b0, n_r});
      else
        rem_r <= rem_sh[4:0];
      rbit_r <= rbit_r - 1'b1;
    end
    if (state_r == ST_MUL_G) begin
      q_old_r <= mdata_s;
      g_r     <= $signed({1'b0, gamma}) * best_r;
    end
    if (state_r == ST_SUM_T)
      t_r <= (Q_W+18)'($signed({reward_r, 16'h0000})) + (Q_W+18)'(g_r >>> 16)
             - (Q_W+18)'(q_old_r);
    if (state_r == ST_MUL_D) d_r <= $signed({1'b0, lr}) * t_r;
    if (state_r == ST_WRITE) o_q_r <= wval;
    if (state_r == ST_SCAN_LAST && !is_upd_r && rbit_r == 5'd0) begin
      if (rval_r < explore_r) begin
        o_move_r <= rem_r[ACT_W-1:0];
        o_rand_r <= 1'b1;
      end else begin
        o_move_r <= arg_r;
      end
    end
  end

  assign out_valid       = out_valid_r;
  assign out_chosen_move = o_move_r;
  assign out_random_used = o_rand_r;
  assign out_q_written   = o_q_r;
  assign out_explore_now = explore_r;

endmodule

/* src/tabular_q_learning_agent.sv */
// tabular_q_learning_agent: top level, configuration registers, sequencer and q table
// depends on tqla_pkg, tqla_qmem, tqla_ctrl
//
//  channel | signals                              | accepted when
//  in      | in_valid/in_stall + 9 fields         | in_valid && !in_stall
//  out     | out_valid/out_stall + 4 fields       | out_valid && !out_stall
//  cfg     | cfg_wr_en, cfg_index, cfg_data       | cfg_wr_en
//
// choose: a row scan issuing one table read per cycle, then a bit-serial remainder tail;
// update: scan of the next row, read, two multiplies, write back
// terminal update: write back only, no scan; end episode and restart: no table access
// after reset the table is cleared one entry per cycle, no items taken then
// one transaction in flight; a held result blocks the next input until taken
module tabular_q_learning_agent
  import tqla_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_wr_en,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DAT_W-1:0]  cfg_data,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [1:0]            in_action,
  input  logic [STATE_W-1:0]    in_state_index,
  input  logic [STATE_W-1:0]    in_from_state,
  input  logic [STATE_W-1:0]    in_next_state,
  input  logic [ACT_W-1:0]      in_taken_move,
  input  logic signed [15:0]    in_reward,
  input  logic                  in_episode_done,
  input  logic [15:0]           in_rand_value,
  input  logic [15:0]           in_rand_pick,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [ACT_W-1:0]      out_chosen_move,
  output logic                  out_random_used,
  output logic signed [Q_W-1:0] out_q_written,
  output logic [15:0]           out_explore_now
);

  // configuration registers
  logic [15:0]       lr_r, gamma_r, exp_init_r, exp_min_r, exp_step_r;
  logic [NACT_W-1:0] nact_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lr_r       <= 16'd6554;
      gamma_r    <= 16'd58982;
      exp_init_r <= 16'd65535;
      exp_min_r  <= 16'd655;
      exp_step_r <= 16'd65;
      nact_r     <= NACT_W'(3);
    end else if (cfg_wr_en) begin
      case (cfg_reg_t'(cfg_index))
        REG_LR:       lr_r       <= cfg_data;
        REG_GAMMA:    gamma_r    <= cfg_data;
        REG_EXP_INIT: exp_init_r <= cfg_data;
        REG_EXP_MIN:  exp_min_r  <= cfg_data;
        REG_EXP_STEP: exp_step_r <= cfg_data;
        REG_NACT:     nact_r     <= cfg_data[NACT_W-1:0];
        default: ;
      endcase
    end
  end

  qmem_req_t      mreq;
  logic [Q_W-1:0] mdata;

  // q table storage
  tqla_qmem u_qmem (
    .clk     (clk),
    .req     (mreq),
    .rd_data (mdata)
  );

  // row scan, update arithmetic and exploration sequencer
  tqla_ctrl u_ctrl (
    .clk             (clk),
    .rst_n           (rst_n),
    .lr              (lr_r),
    .gamma           (gamma_r),
    .exp_init        (exp_init_r),
    .exp_min         (exp_min_r),
    .exp_step        (exp_step_r),
    .nact_cfg        (nact_r),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_action       (in_action),
    .in_state_index  (in_state_index),
    .in_from_state   (in_from_state),
    .in_next_state   (in_next_state),
    .in_taken_move   (in_taken_move),
    .in_reward       (in_reward),
    .in_episode_done (in_episode_done),
    .in_rand_value   (in_rand_value),
    .in_rand_pick    (in_rand_pick),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_chosen_move (out_chosen_move),
    .out_random_used (out_random_used),
    .out_q_written   (out_q_written),
    .out_explore_now (out_explore_now),
    .mreq            (mreq),
    .mdata           (mdata)
  );

  // one transaction at a time: no new input while a result waits
  assert property (@(posedge clk) disable iff (!rst_n) out_valid |-> in_stall)
    else $error("input taken while result pending");

  // a result appears only after the sequencer ran
  assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> !out_valid)
    else $error("result too early");

  // held result stays valid and its q value stable while stalled
  assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> (out_valid && $stable(out_q_written)))
    else $error("result changed while stalled");

endmodule

/* sim/tb.sv */
// tb: self-checking testbench for tabular_q_learning_agent
// depends on tqla_pkg and the tabular_q_learning_agent rtl; directed table then random traffic
module tb;
  import tqla_pkg::*;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_wr_en = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DAT_W-1:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [1:0] in_action = '0;
  logic [9:0] in_state_index = '0;
  logic [9:0] in_from_state = '0;
  logic [9:0] in_next_state = '0;
  logic [3:0] in_taken_move = '0;
  logic signed [15:0] in_reward = '0;
  logic in_episode_done = 1'b0;
  logic [15:0] in_rand_value = '0;
  logic [15:0] in_rand_pick = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [3:0] out_chosen_move;
  logic out_random_used;
  logic signed [31:0] out_q_written;
  logic [15:0] out_explore_now;

  always #10 clk = ~clk;

  tabular_q_learning_agent uut (.*);

  // one input transaction
  typedef struct packed {
    op_t op;
    logic [9:0] st, from, nxt;
    logic [3:0] mv;
    logic signed [15:0] rew;
    logic done;
    logic [15:0] rv, rp;
  } agent_req_t;

  // one result transaction
  typedef struct packed {
    logic [3:0] move;
    logic rnd;
    logic signed [31:0] q;
    logic [15:0] expl;
  } agent_rsp_t;

  // directed row: request plus optional typed-in expectation
  typedef struct packed {
    agent_req_t req;
    logic fixed;
    agent_rsp_t rsp;
  } dir_row_t;

  // shadow of the agent state
  logic signed [31:0] q_shadow [DEPTH];
  logic [15:0] expl_lvl, lr, gam, e_start, e_floor, e_step;
  logic [4:0] n_act;

  agent_rsp_t rsp_queue[$];
  int fails = 0;
  int idle_cycles = 0;
  int snd_idle_pct = 0, rcv_idle_pct = 0;

  function automatic int act_count();
    if (n_act == 0) return 1;
    if (n_act > ACTIONS) return ACTIONS;
    return n_act;
  endfunction

  function automatic int row_max_idx(input logic [9:0] s, output logic signed [31:0] m);
    int a;
    a = 0;
    m = q_shadow[s * ACTIONS];
    for (int i = 1; i < act_count(); i++)
      if (q_shadow[s * ACTIONS + i] > m) begin
        m = q_shadow[s * ACTIONS + i];
        a = i;
      end
    return a;
  endfunction

  // arithmetic shift is floor division by 65536
  function automatic agent_rsp_t predict_agent(input agent_req_t r);
    agent_rsp_t o;
    logic signed [31:0] m;
    longint g, t, d, nv;
    int idx, a;
    o = '0;
    case (r.op)
      OP_CHOOSE: begin
        a = row_max_idx(r.st, m);
        if (r.rv < expl_lvl) begin
          a = int'(r.rp) % act_count();
          o.rnd = 1'b1;
        end
        o.move = a[3:0];
      end
      OP_UPDATE: begin
        idx = r.from * ACTIONS + r.mv;
        if (r.done) nv = longint'(r.rew) * 65536;
        else begin
          void'(row_max_idx(r.nxt, m));
          g = (longint'(gam) * longint'(m)) >>> 16;
          t = longint'(r.rew) * 65536 + g - longint'(q_shadow[idx]);
          d = (longint'(lr) * t) >>> 16;
          nv = longint'(q_shadow[idx]) + d;
          if (nv > 64'sd2147483647) nv = 64'sd2147483647;
          if (nv < -64'sd2147483648) nv = -64'sd2147483648;
        end
        q_shadow[idx] = nv[31:0];
        o.q = nv[31:0];
      end
      OP_END_EP: begin
        if (expl_lvl > e_floor) expl_lvl = (expl_lvl > e_step) ? expl_lvl - e_step : 16'd0;
      end
      default: expl_lvl = e_start;
    endcase
    o.expl = expl_lvl;
    return o;
  endfunction

  // register write while idle, mirrored into the shadow
  task automatic write_reg(input cfg_reg_t idx, input logic [15:0] val);
    @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    case (idx)
      REG_LR: lr = val;
      REG_GAMMA: gam = val;
      REG_EXP_INIT: e_start = val;
      REG_EXP_MIN: e_floor = val;
      REG_EXP_STEP: e_step = val;
      default: n_act = val[4:0];
    endcase
  endtask

  // present one transaction, hold until accepted; stall sampled mid-cycle
  task automatic send_req(input agent_req_t r, input bit fixed, input agent_rsp_t exp_rsp);
    agent_rsp_t p;
    bit took;
    while ($urandom_range(99) < snd_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_action <= r.op;
    in_state_index <= r.st;
    in_from_state <= r.from;
    in_next_state <= r.nxt;
    in_taken_move <= r.mv;
    in_reward <= r.rew;
    in_episode_done <= r.done;
    in_rand_value <= r.rv;
    in_rand_pick <= r.rp;
    do begin
      @(negedge clk);
      took = !in_stall;
      @(posedge clk);
    end while (!took);
    p = predict_agent(r);
    if (fixed) p = exp_rsp;
    rsp_queue = {rsp_queue, p};
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (rsp_queue.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  function automatic agent_req_t rand_req();
    agent_req_t r;
    int k;
    k = $urandom_range(99);
    r.op = k < 40 ? OP_CHOOSE : k < 85 ? OP_UPDATE : k < 96 ? OP_END_EP : OP_RESTART;
    // few hot states so updates build on each other
    r.st = $urandom_range(9) != 0 ? 10'($urandom_range(7)) : 10'($urandom);
    r.from = $urandom_range(9) != 0 ? 10'($urandom_range(7)) : 10'($urandom);
    r.nxt = $urandom_range(9) != 0 ? 10'($urandom_range(7)) : 10'($urandom);
    r.mv = 4'($urandom);
    r.rew = $urandom_range(3) == 0 ? 16'($urandom) : 16'($signed($urandom_range(20)) - 10);
    r.done = ($urandom_range(7) == 0);
    r.rv = 16'($urandom);
    r.rp = 16'($urandom);
    return r;
  endfunction

  // receiver stall
  always @(posedge clk) begin
    if (rst_n) out_stall <= ($urandom_range(99) < rcv_idle_pct);
  end

  // output check, sampled mid-cycle for the coming accepting edge
  always @(negedge clk) begin
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        if (rsp_queue.size() == 0) begin
          $display("%0t unexpected result expected none actual %h", $time,
                   {out_chosen_move, out_random_used, out_q_written, out_explore_now});
          fails++;
        end else begin
          agent_rsp_t e;
          e = rsp_queue.pop_front();
          if (e.move !== out_chosen_move) begin
            $display("%0t chosen_move expected %0d actual %0d", $time, e.move, out_chosen_move);
            fails++;
          end
          if (e.rnd !== out_random_used) begin
            $display("%0t random_used expected %0d actual %0d", $time, e.rnd, out_random_used);
            fails++;
          end
          if (e.q !== out_q_written) begin
            $display("%0t q_written expected %0d actual %0d", $time, e.q, out_q_written);
            fails++;
          end
          if (e.expl !== out_explore_now) begin
            $display("%0t explore_now expected %0d actual %0d", $time, e.expl,
                     out_explore_now);
            fails++;
          end
        end
      end
    end
  end

  // watchdog on cycles with no transaction; covers the table clear after reset
  always @(negedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > 60000) begin
      $display("FAIL");
      $finish;
    end
  end

  dir_row_t dir_rows[$];

  function automatic void add_row(input dir_row_t d);
    dir_rows = {dir_rows, d};
  endfunction

  function automatic dir_row_t mk(input op_t op, input int st, input int from, input int nxt,
                                  input int mv, input int rew, input bit done, input int rv,
                                  input int rp, input bit fixed, input int move,
                                  input bit rnd, input int q, input int expl);
    dir_row_t d;
    d.req = '{op, st[9:0], from[9:0], nxt[9:0], mv[3:0], rew[15:0], done, rv[15:0], rp[15:0]};
    d.fixed = fixed;
    d.rsp = '{move[3:0], rnd, q, expl[15:0]};
    return d;
  endfunction

  initial begin
    agent_rsp_t none;
    none = '0;
    foreach (q_shadow[i]) q_shadow[i] = '0;
    expl_lvl = 16'hFFFF; lr = 6554; gam = 58982; e_start = 16'hFFFF;
    e_floor = 655; e_step = 65; n_act = 3;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // after reset: zero table, full exploration
    add_row(mk(OP_CHOOSE, 0, 0, 0, 0, 0, 0, 65535, 0, 1, 0, 0, 0, 65535));
    add_row(mk(OP_CHOOSE, 1023, 0, 0, 0, 0, 0, 0, 65535, 1, 0, 1, 0, 65535));
    add_row(mk(OP_CHOOSE, 5, 0, 0, 0, 0, 0, 100, 7, 1, 1, 1, 0, 65535));
    // terminal updates store reward exactly, extremes of reward
    add_row(mk(OP_UPDATE, 0, 1023, 0, 15, 32767, 1, 0, 0, 1, 0, 0,
               32767 * 65536, 65535));
    add_row(mk(OP_UPDATE, 0, 2, 0, 1, -32768, 1, 0, 0, 1, 0, 0,
               -32768 * 65536, 65535));
    add_row(mk(OP_UPDATE, 0, 3, 0, 2, 5, 1, 0, 0, 1, 0, 0, 5 * 65536, 65535));
    // non-terminal updates: bootstrap off rows just written, move beyond actions in use
    add_row(mk(OP_UPDATE, 0, 4, 3, 0, 1, 0, 0, 0, 0, 0, 0, 0, 0));
    add_row(mk(OP_UPDATE, 0, 1023, 1023, 15, 32767, 0, 0, 0, 0, 0, 0, 0, 0));
    add_row(mk(OP_UPDATE, 0, 2, 2, 1, -32768, 0, 0, 0, 0, 0, 0, 0, 0));
    // greedy choose with first maximum; row 3 has a 5 at index 2
    add_row(mk(OP_CHOOSE, 3, 0, 0, 0, 0, 0, 65535, 0, 0, 0, 0, 0, 0));
    add_row(mk(OP_CHOOSE, 2, 0, 0, 0, 0, 0, 65535, 0, 0, 0, 0, 0, 0));
    // decay and restart
    add_row(mk(OP_END_EP, 0, 0, 0, 0, 0, 0, 0, 0, 1, 0, 0, 0, 65470));
    add_row(mk(OP_END_EP, 0, 0, 0, 0, 0, 0, 0, 0, 1, 0, 0, 0, 65405));
    add_row(mk(OP_RESTART, 0, 0, 0, 0, 0, 0, 0, 0, 1, 0, 0, 0, 65535));

    snd_idle_pct = 24; rcv_idle_pct = 66;
    foreach (dir_rows[i]) send_req(dir_rows[i].req, dir_rows[i].fixed, dir_rows[i].rsp);
    drain();

    // several register settings, extremes included
    for (int phase = 0; phase < 6; phase++) begin
      case (phase)
        0: begin
          write_reg(REG_LR, 16'hFFFF); write_reg(REG_GAMMA, 16'hFFFF);
          write_reg(REG_EXP_INIT, 16'd0); write_reg(REG_EXP_MIN, 16'd0);
          write_reg(REG_EXP_STEP, 16'hFFFF); write_reg(REG_NACT, 16'd16);
        end
        1: begin
          write_reg(REG_LR, 16'd0); write_reg(REG_GAMMA, 16'd0);
          write_reg(REG_EXP_INIT, 16'hFFFF); write_reg(REG_EXP_MIN, 16'hFFFF);
          write_reg(REG_NACT, 16'd0);
        end
        2: begin
          write_reg(REG_LR, 16'h8000); write_reg(REG_GAMMA, 16'hE666);
          write_reg(REG_EXP_INIT, 16'h8000); write_reg(REG_EXP_MIN, 16'd1000);
          write_reg(REG_EXP_STEP, 16'd3000); write_reg(REG_NACT, 16'd31);
        end
        3: begin
          write_reg(REG_NACT, 16'd1);
          write_reg(REG_LR, 16'($urandom)); write_reg(REG_GAMMA, 16'($urandom));
        end
        4: begin
          write_reg(REG_NACT, 16'($urandom_range(2, 15)));
          write_reg(REG_EXP_STEP, 16'($urandom_range(50, 9000)));
          write_reg(REG_EXP_INIT, 16'($urandom));
        end
        default: begin
          write_reg(REG_LR, 16'd6554); write_reg(REG_GAMMA, 16'd58982);
          write_reg(REG_NACT, 16'd4); write_reg(REG_EXP_MIN, 16'd655);
        end
      endcase
      if (phase == 2) begin snd_idle_pct = 66; rcv_idle_pct = 24; end
      if (phase == 4) begin snd_idle_pct = 0; rcv_idle_pct = 0; end
      for (int n = 0; n < 215; n++) send_req(rand_req(), 1'b0, none);
      drain();
    end

    if (fails == 0) $display("PASS");
    else $display("FAIL");
    $finish;
  end

endmodule

/* tabular_q_learning_agent.f */
src/tqla_pkg.sv
src/tqla_qmem.sv
src/tqla_ctrl.sv
src/tabular_q_learning_agent.sv
sim/tb.sv
